[hdl/lge_pkg.sv]
// Shared types and constants of the life generation engine.
`default_nettype none

package lge_pkg;

	// Operation codes carried by the op field.
	localparam logic [1:0] OP_TOGGLE = 2'd0;
	localparam logic [1:0] OP_STEP   = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;

	localparam int CFG_W      = 7;
	localparam int COORD_W    = 6;
	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	// Neighbor counts of rule B3/S23.
	typedef logic [3:0] count_t;
	localparam count_t BIRTH_N   = 4'd3;
	localparam count_t SURVIVE_N = 4'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_G_RD0,
		ST_G_RDL,
		ST_G_RDN,
		ST_G_ROW,
		ST_RD,
		ST_MOD,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

[hdl/lge_row_unit.sv]
// Next-generation logic for one grid row, with column wraparound at the active width.
`default_nettype none

module lge_row_unit import lge_pkg::*; #(
	parameter int MAX_COLS = 64,
	parameter int NCW      = 7
) (
	input  wire logic [MAX_COLS-1:0] row_up,
	input  wire logic [MAX_COLS-1:0] row_mid,
	input  wire logic [MAX_COLS-1:0] row_down,
	input  wire logic [NCW-1:0]      cols_eff,
	output logic      [MAX_COLS-1:0] row_next
);

	localparam int CW = $clog2(MAX_COLS);

	logic [CW-1:0] wrap_idx;
	logic          up_wrap;
	logic          mid_wrap;
	logic          down_wrap;

	// The left neighbor of column zero is the last active column.
	assign wrap_idx  = CW'(cols_eff - NCW'(1));
	assign up_wrap   = row_up[wrap_idx];
	assign mid_wrap  = row_mid[wrap_idx];
	assign down_wrap = row_down[wrap_idx];

	for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
		localparam int L = (c == 0) ? 0 : c - 1;
		localparam int R = (c == MAX_COLS - 1) ? 0 : c + 1;

		logic   at_first;
		logic   at_last;
		logic   active;
		logic   ul, ur, ml, mr, dl, dr;
		count_t n;
		logic   born;

		assign at_first = (c == 0);
		assign at_last  = (NCW'(c + 1) == cols_eff);
		assign active   = (NCW'(c) < cols_eff);

		assign ul = at_first ? up_wrap   : row_up[L];
		assign ml = at_first ? mid_wrap  : row_mid[L];
		assign dl = at_first ? down_wrap : row_down[L];
		assign ur = at_last  ? row_up[0]   : row_up[R];
		assign mr = at_last  ? row_mid[0]  : row_mid[R];
		assign dr = at_last  ? row_down[0] : row_down[R];

		assign n = count_t'(ul) + count_t'(row_up[c]) + count_t'(ur)
			+ count_t'(ml) + count_t'(mr)
			+ count_t'(dl) + count_t'(row_down[c]) + count_t'(dr);

		assign born = row_mid[c] ? ((n == SURVIVE_N) || (n == BIRTH_N)) : (n == BIRTH_N);

		// Columns beyond the active width keep their contents.
		assign row_next[c] = active ? born : row_mid[c];
	end

endmodule

`default_nettype wire

[hdl/life_generation_engine.sv]
// Top level of the life generation engine: grid store, sequencer and result register.
// Toggle and read: the row is read, the cell toggled or kept, and the result loaded.
// Generation: the first, last and second rows are read, then one grid row per cycle
// goes through the shared row unit into the grid store; the cell is then read as above.
// One request at a time; a result stalled at the output holds the block in its last state.
// Reset clears every grid row and sets both size registers to 64.
`default_nettype none

module life_generation_engine import lge_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,

	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           op,
	input  wire logic [COORD_W-1:0]   cell_row,
	input  wire logic [COORD_W-1:0]   cell_col,

	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      cell_alive,
	output logic                      in_range
);

	// Row address width, column index width, and widths able to hold the full sizes.
	localparam int RW  = $clog2(MAX_ROWS);
	localparam int CW  = $clog2(MAX_COLS);
	localparam int NRW = $clog2(MAX_ROWS + 1);
	localparam int NCW = $clog2(MAX_COLS + 1);

	state_t state_q;
	state_t state_d;

	// Size registers as written, and the sizes they stand for once clamped.
	logic [CFG_W-1:0] rows_q;
	logic [CFG_W-1:0] cols_q;
	logic [NRW-1:0]   rows_eff;
	logic [NCW-1:0]   cols_eff;

	// Latched request.
	logic [1:0]         op_q;
	logic [COORD_W-1:0] row_q;
	logic [COORD_W-1:0] col_q;
	logic               inside_q;
	logic               alive_q;

	// Row sequencing during a generation.
	logic [RW-1:0]  row_cnt_q;
	logic [RW-1:0]  clr_cnt_q;
	logic           last_row;
	logic           clr_done;

	// Three-row window: original top row, original previous row, original current row.
	logic [MAX_COLS-1:0] top_q;
	logic [MAX_COLS-1:0] prev_q;
	logic [MAX_COLS-1:0] cur_q;
	logic [MAX_COLS-1:0] row_down;
	logic [MAX_COLS-1:0] row_next;

	// Grid store, one word per row.
	logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
	logic [MAX_COLS-1:0] rd_data_q;
	logic [RW-1:0]       rd_addr;
	logic                wr_en;
	logic [RW-1:0]       wr_addr;
	logic [MAX_COLS-1:0] wr_data;

	logic [CW-1:0] col_idx;
	logic          rd_bit;
	logic          out_load;
	logic          out_valid_q;
	logic          cell_alive_q;
	logic          in_range_q;

	// Writes are to be issued only while the block is idle; the block does not enforce this, so the port is always open.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CFG_RESET;
			cols_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ROWS: rows_q <= cfg_data;
				CFG_COLS: cols_q <= cfg_data;
			endcase
		end
	end

	// A size of zero acts as one; a size above the store acts as the store size.
	always_comb begin
		if (rows_q == '0) begin
			rows_eff = NRW'(1);
		end else if (32'(rows_q) > 32'(MAX_ROWS)) begin
			rows_eff = NRW'(MAX_ROWS);
		end else begin
			rows_eff = NRW'(rows_q);
		end
		if (cols_q == '0) begin
			cols_eff = NCW'(1);
		end else if (32'(cols_q) > 32'(MAX_COLS)) begin
			cols_eff = NCW'(MAX_COLS);
		end else begin
			cols_eff = NCW'(cols_q);
		end
	end

	assign last_row = ((NRW'(row_cnt_q) + NRW'(1)) == rows_eff);
	assign clr_done = (clr_cnt_q == RW'(MAX_ROWS - 1));
	assign col_idx  = CW'(col_q);
	assign rd_bit   = rd_data_q[col_idx];

	// The row below the last active row is the original top row, saved at the start.
	assign row_down = last_row ? top_q : rd_data_q;

	lge_row_unit #(
		.MAX_COLS (MAX_COLS),
		.NCW      (NCW)
	) u_row_unit (
		.row_up   (prev_q),
		.row_mid  (cur_q),
		.row_down (row_down),
		.cols_eff (cols_eff),
		.row_next (row_next)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_done) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (op == OP_STEP) ? ST_G_RD0 : ST_RD;
				end
			end
			ST_G_RD0: state_d = ST_G_RDL;
			ST_G_RDL: state_d = ST_G_RDN;
			ST_G_RDN: state_d = ST_G_ROW;
			ST_G_ROW: if (last_row) state_d = ST_RD;
			ST_RD:    state_d = ST_MOD;
			ST_MOD:   state_d = ST_OUT;
			ST_OUT:   if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// Output and store-control logic.
	always_comb begin
		in_ready = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = row_cnt_q;
		wr_data  = row_next;
		rd_addr  = RW'(row_q);
		out_load = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_cnt_q;
				wr_data = '0;
			end
			ST_IDLE:  in_ready = 1'b1;
			ST_G_RD0: rd_addr = '0;
			ST_G_RDL: rd_addr = RW'(rows_eff - NRW'(1));
			ST_G_RDN: rd_addr = RW'(1);
			ST_G_ROW: begin
				wr_en   = 1'b1;
				rd_addr = row_cnt_q + RW'(2);
			end
			ST_RD: ;
			ST_MOD: begin
				wr_en   = (op_q == OP_TOGGLE) && inside_q;
				wr_addr = RW'(row_q);
				wr_data = rd_data_q ^ (MAX_COLS'(1) << col_idx);
			end
			ST_OUT:   out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// Grid store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			grid_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= grid_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			row_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + RW'(1);
			end
			if (state_q == ST_G_RD0) begin
				row_cnt_q <= '0;
			end else if (state_q == ST_G_ROW) begin
				row_cnt_q <= row_cnt_q + RW'(1);
			end
		end
	end

	// Request latch and row window; payload only, no reset needed.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q     <= op;
			row_q    <= cell_row;
			col_q    <= cell_col;
			inside_q <= (32'(cell_row) < 32'(rows_eff)) && (32'(cell_col) < 32'(cols_eff));
		end
		unique case (state_q)
			ST_G_RDL: begin
				top_q <= rd_data_q;
				cur_q <= rd_data_q;
			end
			ST_G_RDN: prev_q <= rd_data_q;
			ST_G_ROW: begin
				prev_q <= cur_q;
				cur_q  <= row_down;
			end
			ST_MOD: begin
				alive_q <= inside_q && ((op_q == OP_TOGGLE) ? !rd_bit : rd_bit);
			end
			default: ;
		endcase
	end

	// Result register: the finished request waits here until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			cell_alive_q <= alive_q;
			in_range_q   <= inside_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_alive = cell_alive_q;
	assign in_range   = in_range_q;

`ifndef SYNTHESIS
	// Once a request is taken the block stays busy until its result is built.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high right after an accepted request");

	// No grid write happens while the block is idle.
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !wr_en)
		else $error("grid written while idle");

	// A new result appears only from the result state.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the result state");

	// A live cell is only reported for an address inside the grid in use.
	a_alive_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!cell_alive || in_range))
		else $error("live cell reported out of range");
`endif

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for the toroidal life generation engine.

module tb_top import lge_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// Op code 3 is unused by the block and has to behave like a read.
	localparam logic [1:0] OP_SPARE = 2'd3;

	localparam int GRID_ROWS = 64;
	localparam int GRID_COLS = 64;
	// A generation request is the longest quiet spell; the drain allows for one on the full grid.
	localparam int DRAIN_CYCLES = GRID_ROWS + 16;
	// Cycles in a row with no handshake on any channel before the run gives up.
	localparam int STALL_LIMIT = 3000;
	localparam int RANDOM_PHASES = 23;
	localparam int REQS_PER_PHASE = 50;

	typedef struct packed {
		logic alive;
		logic in_grid;
	} cell_result_t;

	typedef enum logic {
		PLAN_CFG,
		PLAN_REQ
	} plan_kind_t;

	// One line of the directed table. Where typed is set, alive and in_grid hold a
	// result known by inspection; otherwise the predictor supplies the result.
	typedef struct packed {
		plan_kind_t            kind;
		logic [1:0]            opcode;
		logic [COORD_W-1:0]    row;
		logic [COORD_W-1:0]    col;
		logic                  typed;
		logic                  alive;
		logic                  in_grid;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_W-1:0]      reg_val;
	} plan_line_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_ROWS;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [1:0]           op = OP_READ;
	logic [COORD_W-1:0]   cell_row = '0;
	logic [COORD_W-1:0]   cell_col = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 cell_alive;
	logic                 in_range;

	life_generation_engine DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.cell_row   (cell_row),
		.cell_col   (cell_col),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cell_alive (cell_alive),
		.in_range   (in_range)
	);

	always #10 clk = ~clk;

	// Predictor state: our own copy of the grid and of both size registers.
	logic [GRID_COLS-1:0] life_grid [GRID_ROWS];
	logic [CFG_W-1:0]     rows_reg = CFG_RESET;
	logic [CFG_W-1:0]     cols_reg = CFG_RESET;

	// Results still owed by the block, oldest first.
	cell_result_t expected_cells [$];
	cell_result_t want_cell;
	int           fault_count = 0;
	int           quiet_cycles = 0;
	// While set, neither side inserts idle cycles.
	bit           steady = 1'b0;

	plan_line_t directed_plan [$];

	initial begin
		foreach (life_grid[r]) begin
			life_grid[r] = '0;
		end
	end

	// A register value of zero acts as one and anything above the store size saturates.
	function automatic int unsigned active_span(input logic [CFG_W-1:0] value,
			input int unsigned limit);
		if (value == '0) begin
			return 1;
		end
		if (value > limit) begin
			return limit;
		end
		return 32'(value);
	endfunction

	// One B3/S23 generation over the active window. Every neighbor is read from the grid
	// as it stood before the step, with wraparound at the active row and column counts,
	// so small grids count a coinciding position once per occurrence.
	function automatic void evolve_grid(input int unsigned nr, input int unsigned nc);
		logic [GRID_COLS-1:0] prior [GRID_ROWS];
		int unsigned up, dn, lf, rt;
		int n;

		prior = life_grid;
		for (int unsigned r = 0; r < nr; r++) begin
			up = (r == 0) ? nr - 1 : r - 1;
			dn = (r == nr - 1) ? 0 : r + 1;
			for (int unsigned c = 0; c < nc; c++) begin
				lf = (c == 0) ? nc - 1 : c - 1;
				rt = (c == nc - 1) ? 0 : c + 1;
				n = 0;
				n += int'(prior[up][lf]);
				n += int'(prior[up][c]);
				n += int'(prior[up][rt]);
				n += int'(prior[r][lf]);
				n += int'(prior[r][rt]);
				n += int'(prior[dn][lf]);
				n += int'(prior[dn][c]);
				n += int'(prior[dn][rt]);
				if (prior[r][c]) begin
					life_grid[r][c] = (n == SURVIVE_N) || (n == BIRTH_N);
				end else begin
					life_grid[r][c] = (n == BIRTH_N);
				end
			end
		end
	endfunction

	// Applies one accepted request to the predicted grid and returns the cell it reports.
	function automatic cell_result_t apply_request(input logic [1:0] code,
			input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col);
		int unsigned nr;
		int unsigned nc;
		cell_result_t res;

		nr = active_span(rows_reg, GRID_ROWS);
		nc = active_span(cols_reg, GRID_COLS);
		res.in_grid = (row < nr) && (col < nc);
		if (code == OP_TOGGLE) begin
			if (res.in_grid) begin
				life_grid[row][col] = ~life_grid[row][col];
			end
		end else if (code == OP_STEP) begin
			evolve_grid(nr, nc);
		end
		res.alive = res.in_grid ? life_grid[row][col] : 1'b0;
		return res;
	endfunction

	function automatic bit take_break();
		return !steady && ($urandom_range(99) < 32);
	endfunction

	// Presents one request and returns in the time step of the edge that accepted it.
	task automatic send_request(input logic [1:0] code, input logic [COORD_W-1:0] row,
			input logic [COORD_W-1:0] col, input logic typed = 1'b0,
			input logic alive = 1'b0, input logic in_grid = 1'b0);
		cell_result_t res;

		if (take_break()) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (take_break());
		end
		in_valid <= 1'b1;
		op <= code;
		cell_row <= row;
		cell_col <= col;
		do @(posedge clk); while (!in_ready);
		res = apply_request(code, row, col);
		if (typed) begin
			res.alive = alive;
			res.in_grid = in_grid;
		end
		expected_cells = {expected_cells, res};
	endtask

	// Takes the request line down and waits until every owed result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_cells.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_ROWS) begin
			rows_reg = value;
		end else begin
			cols_reg = value;
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Sizes for the random phases: mostly small grids so generations stay short,
	// with zero, full size and oversized values mixed in.
	function automatic logic [CFG_W-1:0] pick_size();
		case ($urandom_range(9))
			0: begin
				return '0;
			end
			1: begin
				return CFG_W'($urandom_range(65, 127));
			end
			2: begin
				return 7'd64;
			end
			3: begin
				return CFG_W'($urandom_range(13, 63));
			end
			4: begin
				return CFG_W'($urandom_range(1, 3));
			end
			default: begin
				return CFG_W'($urandom_range(1, 12));
			end
		endcase
	endfunction

	function automatic plan_line_t req_line(input logic [1:0] code, input int row, input int col);
		plan_line_t line;

		line = '0;
		line.kind = PLAN_REQ;
		line.opcode = code;
		line.row = COORD_W'(row);
		line.col = COORD_W'(col);
		return line;
	endfunction

	function automatic plan_line_t known_line(input logic [1:0] code, input int row,
			input int col, input logic alive, input logic in_grid);
		plan_line_t line;

		line = req_line(code, row, col);
		line.typed = 1'b1;
		line.alive = alive;
		line.in_grid = in_grid;
		return line;
	endfunction

	function automatic plan_line_t cfg_line(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] value);
		plan_line_t line;

		line = '0;
		line.kind = PLAN_CFG;
		line.reg_idx = idx;
		line.reg_val = value;
		return line;
	endfunction

	// Appends one line to the end of the directed table.
	function automatic void plan_add(input plan_line_t line);
		directed_plan = {directed_plan, line};
	endfunction

	// Result side: checks every accepted result against the oldest expectation, then
	// decides whether the next cycle stalls.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_cells.size() == 0) begin
				$error("Result with no request outstanding: cell_alive %0b in_range %0b",
					cell_alive, in_range);
				fault_count++;
			end else begin
				want_cell = expected_cells.pop_front();
				if (cell_alive !== want_cell.alive) begin
					$error("cell_alive: expected %0b, actual %0b", want_cell.alive, cell_alive);
					fault_count++;
				end
				if (in_range !== want_cell.in_grid) begin
					$error("in_range: expected %0b, actual %0b", want_cell.in_grid, in_range);
					fault_count++;
				end
			end
		end
		out_ready <= !take_break();
	end

	// Watchdog: a hung block shows up as a long spell without any handshake.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		logic [1:0]         code;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		int unsigned        nr;
		int unsigned        nc;
		int unsigned        pick;

		// Full grid straight out of reset: everything reads dead, two opposite corners toggle on,
		// and the spare op code reads without changing anything.
		plan_add(known_line(OP_READ, 0, 0, 1'b0, 1'b1));
		plan_add(known_line(OP_READ, 63, 63, 1'b0, 1'b1));
		plan_add(known_line(OP_TOGGLE, 0, 0, 1'b1, 1'b1));
		plan_add(known_line(OP_TOGGLE, 63, 63, 1'b1, 1'b1));
		plan_add(known_line(OP_SPARE, 63, 63, 1'b1, 1'b1));
		// A blinker laid across the column wrap in row 0, then two generations.
		plan_add(req_line(OP_TOGGLE, 0, 63));
		plan_add(req_line(OP_TOGGLE, 0, 1));
		plan_add(req_line(OP_STEP, 63, 0));
		plan_add(req_line(OP_READ, 1, 0));
		plan_add(req_line(OP_STEP, 0, 0));
		// Zero rows acts as one row, an oversized column count saturates. Anything
		// outside the single row is out of range and a toggle there does nothing.
		plan_add(cfg_line(CFG_ROWS, 7'd0));
		plan_add(cfg_line(CFG_COLS, 7'd127));
		plan_add(known_line(OP_READ, 1, 0, 1'b0, 1'b0));
		plan_add(known_line(OP_TOGGLE, 5, 5, 1'b0, 1'b0));
		plan_add(req_line(OP_TOGGLE, 0, 10));
		plan_add(req_line(OP_STEP, 0, 10));
		// Two rows by one column: wrapped neighbors coincide and are counted repeatedly.
		plan_add(cfg_line(CFG_ROWS, 7'd2));
		plan_add(cfg_line(CFG_COLS, 7'd0));
		plan_add(req_line(OP_TOGGLE, 1, 0));
		plan_add(req_line(OP_STEP, 1, 0));
		plan_add(known_line(OP_READ, 0, 1, 1'b0, 1'b0));
		// Three by three torus with a full middle row.
		plan_add(cfg_line(CFG_ROWS, 7'd3));
		plan_add(cfg_line(CFG_COLS, 7'd3));
		plan_add(req_line(OP_TOGGLE, 1, 0));
		plan_add(req_line(OP_TOGGLE, 1, 1));
		plan_add(req_line(OP_TOGGLE, 1, 2));
		plan_add(req_line(OP_STEP, 0, 1));
		plan_add(req_line(OP_STEP, 2, 2));
		// Back to the full grid, the column count given one past the store size. Cells
		// outside the small windows above must have kept their contents.
		plan_add(cfg_line(CFG_ROWS, 7'd64));
		plan_add(cfg_line(CFG_COLS, 7'd65));
		plan_add(req_line(OP_READ, 63, 63));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == PLAN_CFG) begin
				wait_drained();
				write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
			end else begin
				send_request(directed_plan[i].opcode, directed_plan[i].row, directed_plan[i].col,
					directed_plan[i].typed, directed_plan[i].alive, directed_plan[i].in_grid);
			end
		end

		// Random phases: a fresh grid size each phase, then a stream of requests that mostly
		// address cells inside the active window so patterns build up and evolve.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_drained();
			steady = (phase >= 9) && (phase < 12);
			write_reg(CFG_ROWS, pick_size());
			write_reg(CFG_COLS, pick_size());
			nr = active_span(rows_reg, GRID_ROWS);
			nc = active_span(cols_reg, GRID_COLS);
			for (int k = 0; k < REQS_PER_PHASE; k++) begin
				pick = $urandom_range(99);
				if (pick < 40) begin
					code = OP_TOGGLE;
				end else if (pick < 55) begin
					code = OP_STEP;
				end else if (pick < 92) begin
					code = OP_READ;
				end else begin
					code = OP_SPARE;
				end
				if ($urandom_range(99) < 85) begin
					row = COORD_W'($urandom_range(nr - 1));
					col = COORD_W'($urandom_range(nc - 1));
				end else begin
					row = COORD_W'($urandom_range(63));
					col = COORD_W'($urandom_range(63));
				end
				send_request(code, row, col);
			end
		end
		steady = 1'b0;

		// Drain, then leave room for any stray result to show up.
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0 && expected_cells.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[life_generation_engine.f]
hdl/lge_pkg.sv
hdl/lge_row_unit.sv
hdl/life_generation_engine.sv
bench/tb_top.sv
